@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the quaternion unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/qalu_pkg.sv @@
package qalu_pkg;

  localparam int QW    = 32;          // component width
  localparam int PW    = 64;          // 32x32 product
  localparam int SUMW  = 66;          // sums of four products
  localparam int DENW  = 65;          // squared norm, divisor
  localparam int HIW   = SUMW - 32;   // upper slice of a sum
  localparam int PLW   = QW + 33;     // word times lower slice
  localparam int PHW   = QW + HIW;    // word times upper slice
  localparam int NUMW  = 100;         // signed numerator
  localparam int MW    = 100;         // scaled magnitude
  localparam int QBITS = 33;          // quotient bits kept
  localparam int LANES = 4;

  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_INV = 2'd1;
  localparam logic [1:0] OP_ROT = 2'd2;

  typedef logic signed [QW-1:0] word_t;

  typedef struct packed {
    logic [MW-1:0] m;
    logic          neg;
  } lane_t;

  typedef struct packed {
    logic valid;
    logic dz;
  } side_t;

endpackage

@@ hw/rtl/qalu_in_if.sv @@
interface qalu_in_if;
  import qalu_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] op;
  word_t      a_w, a_x, a_y, a_z;
  word_t      b_w, b_x, b_y, b_z;

  modport source(output valid, op, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                 input ready);
  modport sink(input valid, op, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
               output ready);
endinterface

@@ hw/rtl/qalu_out_if.sv @@
interface qalu_out_if;
  import qalu_pkg::*;

  logic  valid;
  logic  ready;
  word_t r_w, r_x, r_y, r_z;
  logic  div_zero;
  logic  saturated;

  modport source(output valid, r_w, r_x, r_y, r_z, div_zero, saturated,
                 input ready);
  modport sink(input valid, r_w, r_x, r_y, r_z, div_zero, saturated,
               output ready);
endinterface

@@ hw/rtl/quaternion_alu.sv @@
// Quaternion unit: Hamilton product, inverse, and vector rotation in fixed point.
// The pipeline has 41 register stages from input transfer to result.
// Throughput: one item per cycle while the result side is not stalled, sustained by the restoring divider pipeline.
// A stall on the result side freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
`include "assert_macros.svh"

module quaternion_alu #(
  parameter int FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  qalu_in_if.sink    cmd,
  qalu_out_if.source rsp
);
  import qalu_pkg::*;

  logic                        en;
  side_t                       fr_side;
  lane_t [LANES-1:0]           fr_lane;
  logic [DENW-1:0]             fr_den;
  side_t                       dv_side;
  logic [LANES-1:0][QW-1:0]    dv_r;
  logic                        dv_sat;

  // advance when the output register is empty or being drained
  assign en        = ~dv_side.valid | rsp.ready;
  assign cmd.ready = en;

  qalu_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (cmd.valid),
    .op       (cmd.op),
    .a_w      (cmd.a_w),
    .a_x      (cmd.a_x),
    .a_y      (cmd.a_y),
    .a_z      (cmd.a_z),
    .b_w      (cmd.b_w),
    .b_x      (cmd.b_x),
    .b_y      (cmd.b_y),
    .b_z      (cmd.b_z),
    .side     (fr_side),
    .lane     (fr_lane),
    .den      (fr_den)
  );

  qalu_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .side_in (fr_side),
    .lane_in (fr_lane),
    .den_in  (fr_den),
    .side    (dv_side),
    .r       (dv_r),
    .sat     (dv_sat)
  );

  assign rsp.valid     = dv_side.valid;
  assign rsp.r_w       = $signed(dv_r[0]);
  assign rsp.r_x       = $signed(dv_r[1]);
  assign rsp.r_y       = $signed(dv_r[2]);
  assign rsp.r_z       = $signed(dv_r[3]);
  assign rsp.div_zero  = dv_side.dz;
  assign rsp.saturated = dv_sat;

  // a zero norm result carries zeros and never clips
  `ASSERT_CLK(a_dz_zero, rsp.valid && rsp.div_zero |-> (rsp.r_w == 0 && rsp.r_x == 0 && rsp.r_y == 0 && rsp.r_z == 0 && !rsp.saturated), "zero norm result not clean")

  // no result leaves right after reset
  `ASSERT_ALWAYS(a_rst_empty, $past(rst) |-> !rsp.valid, "result valid after reset")

  // a stalled result stays valid and keeps its x component and saturation flag
  `ASSERT_CLK(a_stall_hold, rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.r_x) && $stable(rsp.saturated), "stalled result changed")

endmodule

@@ hw/rtl/qalu_front.sv @@
module qalu_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [1:0]                             op,
  input  qalu_pkg::word_t                        a_w,
  input  qalu_pkg::word_t                        a_x,
  input  qalu_pkg::word_t                        a_y,
  input  qalu_pkg::word_t                        a_z,
  input  qalu_pkg::word_t                        b_w,
  input  qalu_pkg::word_t                        b_x,
  input  qalu_pkg::word_t                        b_y,
  input  qalu_pkg::word_t                        b_z,
  output qalu_pkg::side_t                        side,
  output qalu_pkg::lane_t [qalu_pkg::LANES-1:0] lane,
  output logic [qalu_pkg::DENW-1:0]             den
);
  import qalu_pkg::*;

  word_t aa [4];
  word_t bb [4];

  logic [4:0] vld;
  logic       vld6;
  logic       dz6;

  // stage 1
  logic signed [PW-1:0] prod1 [4][4];
  logic signed [PW-1:0] sq1 [4];
  word_t                a1 [4];
  word_t                b1 [3];
  logic [1:0]           op1;

  // stage 2
  logic signed [SUMW-1:0] s2 [4];
  logic signed [SUMW-1:0] k2, d2;
  logic signed [SUMW-1:0] c2 [3];
  logic [DENW-1:0]        n2;
  logic                   zero2;
  word_t                  a2 [4];
  word_t                  b2 [3];
  logic [1:0]             op2;
  logic signed [SUMW-1:0] nsum;

  // stage 3
  logic signed [PLW-1:0]  pl3 [3][3];
  logic signed [PHW-1:0]  ph3 [3][3];
  logic signed [SUMW-1:0] s3 [4];
  logic [DENW-1:0]        n3;
  logic                   zero3;
  word_t                  a3 [4];
  logic [1:0]             op3;
  word_t                  mul2 [3][3];
  logic signed [SUMW-1:0] xv2 [3][3];

  // stage 4
  logic signed [NUMW-1:0] t4 [3][3];
  logic signed [SUMW-1:0] s4 [4];
  logic [DENW-1:0]        n4;
  logic                   zero4;
  word_t                  a4 [4];
  logic [1:0]             op4;

  // stage 5
  logic signed [NUMW-1:0] p5 [4];
  logic signed [SUMW-1:0] s5 [4];
  logic [DENW-1:0]        n5;
  logic                   zero5;
  word_t                  a5 [4];
  logic [1:0]             op5;

  // stage 6 inputs
  logic signed [NUMW-1:0] num [LANES];
  logic [NUMW-1:0]        mag [LANES];
  logic [MW-1:0]          mm [LANES];
  logic                   ng [LANES];
  logic [DENW-1:0]        den_c;
  logic                   dz_c;

  assign aa[0] = a_w;
  assign aa[1] = a_x;
  assign aa[2] = a_y;
  assign aa[3] = a_z;
  assign bb[0] = b_w;
  assign bb[1] = b_x;
  assign bb[2] = b_y;
  assign bb[3] = b_z;

  assign side = '{valid: vld6, dz: dz6};

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      vld6 <= 1'b0;
    end else if (en) begin
      vld  <= {vld[3:0], in_valid};
      vld6 <= vld[4];
    end
  end

  // stage 1: all cross products and squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod1[i][j] <= PW'(aa[i]) * PW'(bb[j]);
        end
        sq1[i] <= PW'(aa[i]) * PW'(aa[i]);
        a1[i]  <= aa[i];
      end
      for (int i = 0; i < 3; i++) begin
        b1[i] <= bb[i+1];
      end
      op1 <= op;
    end
  end

  // stage 2: product sums, norm, rotation terms
  assign nsum = SUMW'(sq1[0]) + SUMW'(sq1[1]) + SUMW'(sq1[2]) + SUMW'(sq1[3]);

  always_ff @(posedge clk) begin
    if (en) begin
      s2[0] <= SUMW'(prod1[0][0]) - SUMW'(prod1[1][1]) - SUMW'(prod1[2][2])
               - SUMW'(prod1[3][3]);
      s2[1] <= SUMW'(prod1[1][0]) + SUMW'(prod1[0][1]) + SUMW'(prod1[2][3])
               - SUMW'(prod1[3][2]);
      s2[2] <= SUMW'(prod1[0][2]) - SUMW'(prod1[1][3]) + SUMW'(prod1[2][0])
               + SUMW'(prod1[3][1]);
      s2[3] <= SUMW'(prod1[0][3]) + SUMW'(prod1[1][2]) - SUMW'(prod1[2][1])
               + SUMW'(prod1[3][0]);
      k2    <= SUMW'(sq1[0]) - SUMW'(sq1[1]) - SUMW'(sq1[2]) - SUMW'(sq1[3]);
      d2    <= SUMW'(prod1[1][1]) + SUMW'(prod1[2][2]) + SUMW'(prod1[3][3]);
      c2[0] <= SUMW'(prod1[2][3]) - SUMW'(prod1[3][2]);
      c2[1] <= SUMW'(prod1[3][1]) - SUMW'(prod1[1][3]);
      c2[2] <= SUMW'(prod1[1][2]) - SUMW'(prod1[2][1]);
      n2    <= nsum[DENW-1:0];
      zero2 <= (nsum == '0);
      a2    <= a1;
      b2    <= b1;
      op2   <= op1;
    end
  end

  // stage 3: split wide rotation terms into partial products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mul2[i][0] = b2[i];
      mul2[i][1] = a2[i+1];
      mul2[i][2] = a2[0];
      xv2[i][0]  = k2;
      xv2[i][1]  = d2;
      xv2[i][2]  = c2[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int t = 0; t < 3; t++) begin
          pl3[i][t] <= PLW'(mul2[i][t]) * PLW'($signed({1'b0, xv2[i][t][31:0]}));
          ph3[i][t] <= PHW'(mul2[i][t]) * PHW'($signed(xv2[i][t][SUMW-1:32]));
        end
      end
      s3    <= s2;
      n3    <= n2;
      zero3 <= zero2;
      a3    <= a2;
      op3   <= op2;
    end
  end

  // stage 4: rejoin partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int t = 0; t < 3; t++) begin
          t4[i][t] <= (NUMW'(ph3[i][t]) <<< 32) + NUMW'(pl3[i][t]);
        end
      end
      s4    <= s3;
      n4    <= n3;
      zero4 <= zero3;
      a4    <= a3;
      op4   <= op3;
    end
  end

  // stage 5: vector part of a*v*conj(a)
  always_ff @(posedge clk) begin
    if (en) begin
      p5[0] <= '0;
      for (int i = 0; i < 3; i++) begin
        p5[i+1] <= t4[i][0] + (t4[i][1] <<< 1) + (t4[i][2] <<< 1);
      end
      s5    <= s4;
      n5    <= n4;
      zero5 <= zero4;
      a5    <= a4;
      op5   <= op4;
    end
  end

  // stage 6: pick numerator per lane, take magnitude, scale
  assign dz_c = zero5 & (op5 == OP_INV || op5 == OP_ROT);

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      case (op5)
        OP_MUL:  num[j] = NUMW'(s5[j]);
        OP_INV:  num[j] = (j == 0) ? NUMW'(a5[0]) : -NUMW'(a5[j]);
        OP_ROT:  num[j] = p5[j];
        default: num[j] = '0;
      endcase
      if (dz_c) begin
        num[j] = '0;
      end
      ng[j]  = num[j][NUMW-1];
      mag[j] = ng[j] ? NUMW'(-num[j]) : NUMW'(num[j]);
      if (op5 == OP_INV) begin
        mm[j] = MW'(mag[j] << (2 * FRAC_BITS + 1));
      end else begin
        mm[j] = MW'(mag[j] << 1);
      end
    end
  end

  always_comb begin
    case (op5)
      OP_MUL:  den_c = DENW'(1) << FRAC_BITS;
      OP_INV:  den_c = zero5 ? DENW'(1) : n5;
      OP_ROT:  den_c = zero5 ? DENW'(1) : n5;
      default: den_c = DENW'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < LANES; j++) begin
        lane[j].m   <= mm[j];
        lane[j].neg <= ng[j];
      end
      den <= den_c;
      dz6 <= dz_c;
    end
  end

endmodule

@@ hw/rtl/qalu_div.sv @@
module qalu_div (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  qalu_pkg::side_t                             side_in,
  input  qalu_pkg::lane_t [qalu_pkg::LANES-1:0]      lane_in,
  input  logic [qalu_pkg::DENW-1:0]                  den_in,
  output qalu_pkg::side_t                             side,
  output logic [qalu_pkg::LANES-1:0][qalu_pkg::QW-1:0] r,
  output logic                                        sat
);
  import qalu_pkg::*;

  localparam int NS  = QBITS + 1;
  localparam int HMW = MW - QBITS;
  localparam logic [QBITS-1:0] LIM_POS = QBITS'(32'h7FFF_FFFF);
  localparam logic [QBITS-1:0] LIM_NEG = QBITS'(32'h8000_0000);

  logic [NS-1:0]    vld;
  logic             dzs [NS];
  logic [DENW-1:0]  dn [NS];
  logic [DENW-1:0]  rem [NS][LANES];
  logic [QBITS-1:0] lo [NS][LANES];
  logic [QBITS-1:0] quo [NS][LANES];
  logic             ng [NS][LANES];
  logic             ov [NS][LANES];

  logic [HMW-1:0]   hi_m [LANES];
  logic             ov0 [LANES];
  logic [DENW-1:0]  rem_next [NS][LANES];
  logic             take [NS][LANES];

  logic [QW-1:0]    r_next [LANES];
  logic [LANES-1:0] clip;
  logic             vld_out;
  logic             dz_out;

  assign side = '{valid: vld_out, dz: dz_out};

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      vld_out <= 1'b0;
    end else if (en) begin
      vld     <= {vld[NS-2:0], side_in.valid};
      vld_out <= vld[NS-1];
    end
  end

  // entry: quotients of 2^QBITS or more clip anyway
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      hi_m[j] = lane_in[j].m[MW-1:QBITS];
      ov0[j]  = hi_m[j] >= HMW'(den_in);
    end
  end

  // one restoring step per stage
  always_comb begin
    logic [DENW:0]   trial;
    logic [DENW+1:0] diff;
    for (int j = 0; j < LANES; j++) begin
      rem_next[0][j] = ov0[j] ? '0 : hi_m[j][DENW-1:0];
      take[0][j]     = 1'b0;
    end
    for (int k = 1; k < NS; k++) begin
      for (int j = 0; j < LANES; j++) begin
        trial          = {rem[k-1][j], lo[k-1][j][QBITS-1]};
        diff           = {1'b0, trial} - (DENW+2)'(dn[k-1]);
        take[k][j]     = ~diff[DENW+1];
        rem_next[k][j] = take[k][j] ? diff[DENW-1:0] : trial[DENW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn[0]  <= den_in;
      dzs[0] <= side_in.dz;
      for (int j = 0; j < LANES; j++) begin
        rem[0][j] <= rem_next[0][j];
        lo[0][j]  <= lane_in[j].m[QBITS-1:0];
        quo[0][j] <= '0;
        ng[0][j]  <= lane_in[j].neg;
        ov[0][j]  <= ov0[j];
      end
      for (int k = 1; k < NS; k++) begin
        dn[k]  <= dn[k-1];
        dzs[k] <= dzs[k-1];
        for (int j = 0; j < LANES; j++) begin
          rem[k][j] <= rem_next[k][j];
          lo[k][j]  <= lo[k-1][j] << 1;
          quo[k][j] <= {quo[k-1][j][QBITS-2:0], take[k][j]};
          ng[k][j]  <= ng[k-1][j];
          ov[k][j]  <= ov[k-1][j];
        end
      end
    end
  end

  // round half away from zero, clip, restore sign
  always_comb begin
    logic [QBITS:0]   sum;
    logic [QBITS-1:0] fin;
    logic [QBITS-1:0] lim;
    logic [QBITS-1:0] mv;
    logic [QBITS-1:0] sv;
    for (int j = 0; j < LANES; j++) begin
      sum       = {1'b0, quo[NS-1][j]} + (QBITS+1)'(1);
      fin       = sum[QBITS:1];
      lim       = ng[NS-1][j] ? LIM_NEG : LIM_POS;
      clip[j]   = ov[NS-1][j] | (fin > lim);
      mv        = clip[j] ? lim : fin;
      sv        = ng[NS-1][j] ? -mv : mv;
      r_next[j] = sv[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < LANES; j++) begin
        r[j] <= r_next[j];
      end
      sat    <= |clip;
      dz_out <= dzs[NS-1];
    end
  end

endmodule
